>>> sv/pixel_format_converter_unit_assert.svh
// Assertion macros for the pixel format converter.
`ifndef PIXEL_FORMAT_CONVERTER_UNIT_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfc assertion failed");

// Consequent checked a fixed number of cycles after the antecedent.
`define PFC_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("pfc assertion failed");

`endif

>>> sv/pfc_pkg.sv
package pfc_pkg;

  localparam logic [3:0] FMT_AUTO     = 4'd0;
  localparam logic [3:0] FMT_I8       = 4'd1;
  localparam logic [3:0] FMT_AI88     = 4'd2;
  localparam logic [3:0] FMT_RGB888   = 4'd3;
  localparam logic [3:0] FMT_RGBA8888 = 4'd4;
  localparam logic [3:0] FMT_RGB565   = 4'd5;
  localparam logic [3:0] FMT_A8       = 4'd6;
  localparam logic [3:0] FMT_RGBA4444 = 4'd7;
  localparam logic [3:0] FMT_RGB5A1   = 4'd8;

  localparam logic [0:0] REG_SRC_FMT = 1'b0;
  localparam logic [0:0] REG_DST_FMT = 1'b1;

  localparam logic [8:0]  LUMA_R = 9'd299;
  localparam logic [9:0]  LUMA_G = 10'd587;
  localparam logic [6:0]  LUMA_B = 7'd114;
  localparam logic [8:0]  LUMA_RND = 9'd500;
  // floor(s / 1000) == (s * ceil(2^28 / 1000)) >> 28 for every s below 2^18
  localparam logic [18:0] LUMA_RECIP = 19'd268436;
  localparam int unsigned LUMA_SHIFT = 28;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // supported destination codes per source code, bit t = target code t
  localparam logic [7:0][15:0] SUPPORTED = '{
    16'h0000, 16'h0000, 16'h0000,
    16'h01EE,   // RGBA8888
    16'h01B6,   // RGB888
    16'h01FA,   // AI88
    16'h01BC,   // I8
    16'h0000
  };

  typedef struct packed {
    logic        convert;
    logic [3:0]  fmt;
    logic [2:0]  nbytes;
    logic [31:0] pass_pix;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        last;
  } pix_ctrl_t;

endpackage

>>> sv/pfc_decode.sv
module pfc_decode import pfc_pkg::*; (
  input  logic [2:0]  src_fmt_i,
  input  logic [3:0]  dst_fmt_i,
  input  logic [7:0]  byte0_i,
  input  logic [7:0]  byte1_i,
  input  logic [7:0]  byte2_i,
  input  logic [7:0]  byte3_i,
  input  logic        last_i,
  output pix_ctrl_t   ctrl_o
);

  logic        valid_src;
  logic [15:0] mask;
  logic [3:0]  src4;
  logic [31:0] all_bytes;

  assign src4      = {1'b0, src_fmt_i};
  assign valid_src = (src4 == FMT_I8) || (src4 == FMT_AI88) ||
                     (src4 == FMT_RGB888) || (src4 == FMT_RGBA8888);
  assign mask      = SUPPORTED[src_fmt_i];
  assign all_bytes = {byte3_i, byte2_i, byte1_i, byte0_i};

  always_comb begin
    ctrl_o.convert = valid_src && (dst_fmt_i != FMT_AUTO) && (dst_fmt_i != src4) &&
                     mask[dst_fmt_i];
    ctrl_o.last    = last_i;
    ctrl_o.r       = byte0_i;
    ctrl_o.g       = byte1_i;
    ctrl_o.b       = byte2_i;
    ctrl_o.a       = byte3_i;
    ctrl_o.fmt     = ctrl_o.convert ? dst_fmt_i : src4;
    ctrl_o.nbytes  = valid_src ? src_fmt_i : 3'd4;
    ctrl_o.pass_pix = all_bytes;
    case (src4)
      FMT_I8: begin
        ctrl_o.g        = byte0_i;
        ctrl_o.b        = byte0_i;
        ctrl_o.a        = ALPHA_OPAQUE;
        ctrl_o.pass_pix = {24'd0, byte0_i};
      end
      FMT_AI88: begin
        ctrl_o.g        = byte0_i;
        ctrl_o.b        = byte0_i;
        ctrl_o.a        = byte1_i;
        ctrl_o.pass_pix = {16'd0, byte1_i, byte0_i};
      end
      FMT_RGB888: begin
        ctrl_o.a        = ALPHA_OPAQUE;
        ctrl_o.pass_pix = {8'd0, byte2_i, byte1_i, byte0_i};
      end
      default: ;
    endcase
  end

endmodule

>>> sv/pfc_luma.sv
module pfc_luma import pfc_pkg::*; (
  input  logic       clk_i,
  input  logic [7:0] r_i,
  input  logic [7:0] g_i,
  input  logic [7:0] b_i,
  output logic [7:0] y_o
);

  // three stages: weighted products, rounded sum, reciprocal product
  logic [16:0] pr_d, pr_q;
  logic [17:0] pg_d, pg_q;
  logic [14:0] pb_d, pb_q;
  logic [17:0] sum_d, sum_q;
  logic [36:0] quo_d, quo_q;

  assign pr_d  = 17'(r_i) * 17'(LUMA_R);
  assign pg_d  = 18'(g_i) * 18'(LUMA_G);
  assign pb_d  = 15'(b_i) * 15'(LUMA_B);
  assign sum_d = 18'(pr_q) + pg_q + 18'(pb_q) + 18'(LUMA_RND);
  assign quo_d = 37'(sum_q) * 37'(LUMA_RECIP);

  always_ff @(posedge clk_i) begin
    pr_q  <= pr_d;
    pg_q  <= pg_d;
    pb_q  <= pb_d;
    sum_q <= sum_d;
    quo_q <= quo_d;
  end

  assign y_o = quo_q[LUMA_SHIFT +: 8];

endmodule

>>> sv/pfc_pack.sv
module pfc_pack import pfc_pkg::*; (
  input  pix_ctrl_t   ctrl_i,
  input  logic [7:0]  y_i,
  output logic [31:0] pix_o,
  output logic [2:0]  nbytes_o
);

  always_comb begin
    pix_o    = ctrl_i.pass_pix;
    nbytes_o = ctrl_i.nbytes;
    if (ctrl_i.convert) begin
      case (ctrl_i.fmt)
        FMT_I8: begin
          pix_o    = {24'd0, y_i};
          nbytes_o = 3'd1;
        end
        FMT_AI88: begin
          pix_o    = {16'd0, ctrl_i.a, y_i};
          nbytes_o = 3'd2;
        end
        FMT_RGB888: begin
          pix_o    = {8'd0, ctrl_i.b, ctrl_i.g, ctrl_i.r};
          nbytes_o = 3'd3;
        end
        FMT_RGBA8888: begin
          pix_o    = {ctrl_i.a, ctrl_i.b, ctrl_i.g, ctrl_i.r};
          nbytes_o = 3'd4;
        end
        FMT_RGB565: begin
          pix_o    = {16'd0, ctrl_i.r[7:3], ctrl_i.g[7:2], ctrl_i.b[7:3]};
          nbytes_o = 3'd2;
        end
        FMT_A8: begin
          pix_o    = {24'd0, ctrl_i.a};
          nbytes_o = 3'd1;
        end
        FMT_RGBA4444: begin
          pix_o    = {16'd0, ctrl_i.r[7:4], ctrl_i.g[7:4], ctrl_i.b[7:4], ctrl_i.a[7:4]};
          nbytes_o = 3'd2;
        end
        default: begin // RGB5A1
          pix_o    = {16'd0, ctrl_i.r[7:3], ctrl_i.g[7:3], ctrl_i.b[7:3], ctrl_i.a[7]};
          nbytes_o = 3'd2;
        end
      endcase
    end
  end

endmodule

>>> sv/pixel_format_converter_unit.sv
// Channel   Handshake            Payload
// input     start_i / busy_o     pix_byte0_i..pix_byte3_i, last_pixel_i
// result    done_o (strobe)      out_pixel_o, out_bytes_o, out_format_o, last_out_o
// config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// One pixel per cycle while busy_o is low.
// Each result follows the luma path: products, sum, reciprocal multiply, pack.
// busy_o is high during reset and in the first cycle after it, then stays low.
// Results cannot be stalled; done_o marks each for exactly one cycle.
// Formats are sampled when the pixel is transferred.
module pixel_format_converter_unit import pfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  pix_byte0_i,
  input  logic [7:0]  pix_byte1_i,
  input  logic [7:0]  pix_byte2_i,
  input  logic [7:0]  pix_byte3_i,
  input  logic        last_pixel_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [31:0] out_pixel_o,
  output logic [2:0]  out_bytes_o,
  output logic [3:0]  out_format_o,
  output logic        last_out_o
);

`include "pixel_format_converter_unit_assert.svh"

  localparam int unsigned Depth = 3;

  logic [2:0]  src_fmt_q;
  logic [3:0]  dst_fmt_q;
  logic        busy_q;
  logic        take;
  pix_ctrl_t   ctrl_in;
  pix_ctrl_t   ctrl_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [7:0]  luma_y;
  logic [31:0] pix_d, pix_q;
  logic [2:0]  nbytes_d, nbytes_q;
  logic [3:0]  fmt_q;
  logic        last_q;
  logic        done_q;

  assign take = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= FMT_RGBA8888[2:0];
      dst_fmt_q <= FMT_AUTO;
      busy_q    <= 1'b1;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SRC_FMT: src_fmt_q <= cfg_wdata_i[2:0];
          REG_DST_FMT: dst_fmt_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  pfc_decode u_decode (
    .src_fmt_i (src_fmt_q),
    .dst_fmt_i (dst_fmt_q),
    .byte0_i   (pix_byte0_i),
    .byte1_i   (pix_byte1_i),
    .byte2_i   (pix_byte2_i),
    .byte3_i   (pix_byte3_i),
    .last_i    (last_pixel_i),
    .ctrl_o    (ctrl_in)
  );

  pfc_luma u_luma (
    .clk_i (clk_i),
    .r_i   (ctrl_in.r),
    .g_i   (ctrl_in.g),
    .b_i   (ctrl_in.b),
    .y_o   (luma_y)
  );

  // control travels alongside the luma stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Depth-2:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q[0] <= ctrl_in;
    for (int i = 1; i < Depth; i++) begin
      ctrl_q[i] <= ctrl_q[i-1];
    end
  end

  pfc_pack u_pack (
    .ctrl_i   (ctrl_q[Depth-1]),
    .y_i      (luma_y),
    .pix_o    (pix_d),
    .nbytes_o (nbytes_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q    <= pix_d;
    nbytes_q <= nbytes_d;
    fmt_q    <= ctrl_q[Depth-1].fmt;
    last_q   <= ctrl_q[Depth-1].last;
  end

  assign busy_o       = busy_q;
  assign done_o       = done_q;
  assign out_pixel_o  = pix_q;
  assign out_bytes_o  = nbytes_q;
  assign out_format_o = fmt_q;
  assign last_out_o   = last_q;

  `PFC_ASSERT_DELAY(a_latency, clk_i, rst_ni, start_i && !busy_o, 4, done_o)
  `PFC_ASSERT_IMPLY(a_bytes_range, clk_i, rst_ni, done_o,
                    out_bytes_o != 3'd0 && out_bytes_o <= 3'd4)
  `PFC_ASSERT_IMPLY(a_one_byte_clean, clk_i, rst_ni, done_o && out_bytes_o == 3'd1,
                    out_pixel_o[31:8] == 24'd0)
  `PFC_ASSERT_IMPLY(a_narrow_clean, clk_i, rst_ni, done_o && out_bytes_o == 3'd2,
                    out_pixel_o[31:16] == 16'd0)

endmodule
